FILE: rtl/core/rop_pkg.sv
// shared types, constants and the per-channel blend function for the rectangle overlay
`timescale 1ns / 1ps
`default_nettype none
package rop_pkg;

  localparam int COORD_BITS_DEF = 14;
  localparam int PIX_BITS       = 13;
  localparam int CFG_DATA_W     = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int BAR_CELLS      = 4;
  localparam int COUNT_W        = 3;

  localparam logic [7:0] ALPHA_MAX = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THICKNESS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE   = 3'd7;

  // draw_mode bits
  localparam int MODE_OUTLINE_BIT = 0;
  localparam int MODE_SET_BIT     = 1;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_x;
    logic [PIX_BITS-1:0] pixel_y;
    logic [7:0]          dst_b;
    logic [7:0]          dst_g;
    logic [7:0]          dst_r;
    logic [7:0]          dst_a;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0]         out_b;
    logic [7:0]         out_g;
    logic [7:0]         out_r;
    logic [7:0]         out_a;
    logic [COUNT_W-1:0] cover_count;
  } pixel_out_t;

  typedef struct packed {
    logic [23:0] fill_color;
    logic [7:0]  blend_alpha;
    logic [1:0]  draw_mode;
  } blend_cfg_t;

  // floor((d*(255-a) + c*a) / 255), sum stays below 65535
  function automatic logic [7:0] mix8(input logic [7:0] d, input logic [7:0] c,
                                      input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] s;
    p = 16'(d) * 16'(ALPHA_MAX - a) + 16'(c) * 16'(a);
    s = 17'(p) + 17'd1 + 17'(p[15:8]);
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rop_cover.sv
// first cell: rectangle and outline bar coverage count for one pixel
`timescale 1ns / 1ps
`default_nettype none
module rop_cover
  import rop_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire pixel_in_t                    in_word,
  input  wire logic signed [COORD_BITS-1:0] rect_left,
  input  wire logic signed [COORD_BITS-1:0] rect_top,
  input  wire logic signed [COORD_BITS-1:0] rect_right,
  input  wire logic signed [COORD_BITS-1:0] rect_bottom,
  input  wire logic [7:0]                   outline_thickness,
  input  wire logic [1:0]                   draw_mode,
  output logic                              cell_valid,
  output pixel_out_t                        cell_word
);

  localparam int W = COORD_BITS + 2;

  logic signed [W-1:0] xs, ys, ls, ts, rs, bs, th;
  logic signed [W-1:0] top_end, bot_start, left_end, right_start;
  logic [COUNT_W-1:0]  count;

  function automatic logic in_box(input logic signed [W-1:0] x, input logic signed [W-1:0] y,
                                  input logic signed [W-1:0] l, input logic signed [W-1:0] t,
                                  input logic signed [W-1:0] r, input logic signed [W-1:0] b);
    return (x >= l) && (x < r) && (y >= t) && (y < b);
  endfunction

  assign xs = {{(W-PIX_BITS){1'b0}}, in_word.pixel_x};
  assign ys = {{(W-PIX_BITS){1'b0}}, in_word.pixel_y};
  assign ls = {{2{rect_left[COORD_BITS-1]}}, rect_left};
  assign ts = {{2{rect_top[COORD_BITS-1]}}, rect_top};
  assign rs = {{2{rect_right[COORD_BITS-1]}}, rect_right};
  assign bs = {{2{rect_bottom[COORD_BITS-1]}}, rect_bottom};
  assign th = {{(W-8){1'b0}}, outline_thickness};

  assign top_end     = ts + th;
  assign bot_start   = bs - th;
  assign left_end    = ls + th;
  assign right_start = rs - th;

  always_comb begin
    if (!draw_mode[MODE_OUTLINE_BIT]) begin
      count = {{(COUNT_W-1){1'b0}}, in_box(xs, ys, ls, ts, rs, bs)};
    end else begin
      count = COUNT_W'(in_box(xs, ys, ls, ts, rs, top_end))
            + COUNT_W'(in_box(xs, ys, ls, bot_start, rs, bs))
            + COUNT_W'(in_box(xs, ys, ls, ts, left_end, bs))
            + COUNT_W'(in_box(xs, ys, right_start, ts, rs, bs));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (adv) begin
      cell_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_word.out_b       <= in_word.dst_b;
      cell_word.out_g       <= in_word.dst_g;
      cell_word.out_r       <= in_word.dst_r;
      cell_word.out_a       <= in_word.dst_a;
      cell_word.cover_count <= count;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rop_blend_cell.sv
// one blend cell: in blend mode, mixes color once when over IDX bars cover the pixel
`timescale 1ns / 1ps
`default_nettype none
module rop_blend_cell
  import rop_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire blend_cfg_t cfg,
  input  wire logic       prev_valid,
  input  wire pixel_out_t prev_word,
  output logic            cell_valid,
  output pixel_out_t      cell_word
);

  logic       apply;
  pixel_out_t cell_word_next;

  assign apply = !cfg.draw_mode[MODE_SET_BIT] && (prev_word.cover_count > COUNT_W'(IDX));

  always_comb begin
    cell_word_next = prev_word;
    if (apply) begin
      cell_word_next.out_b = mix8(prev_word.out_b, cfg.fill_color[7:0], cfg.blend_alpha);
      cell_word_next.out_g = mix8(prev_word.out_g, cfg.fill_color[15:8], cfg.blend_alpha);
      cell_word_next.out_r = mix8(prev_word.out_r, cfg.fill_color[23:16], cfg.blend_alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (adv) begin
      cell_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_word <= cell_word_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rect_overlay_pixel_blend_unit.sv
// top level: config registers, coverage cell, chain of blend cells and output register
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+--------------------------------
//   in      | input     | in_valid/in_stall  | pixel_in_t: x, y, dst bgra
//   out     | output    | out_valid/out_stall| pixel_out_t: bgra, cover_count
//   cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// one pixel per clock while the output is not stalled, through coverage cell, four
// blend cells, output register. blend mode mixes an n-bar pixel in the first n cells.
// rst is synchronous and clears all valid flags and config registers to defaults.
// the whole chain holds while out_valid is high and out_stall is high; in_stall
// follows that condition.
`timescale 1ns / 1ps
`default_nettype none
module rect_overlay_pixel_blend_unit
  import rop_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pixel_in_t             in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pixel_out_t                 out_word
);

  logic signed [COORD_BITS-1:0] rect_left, rect_top, rect_right, rect_bottom;
  logic [7:0]  outline_thickness;
  logic [23:0] fill_color;
  logic [7:0]  blend_alpha;
  logic [1:0]  draw_mode;
  blend_cfg_t  bcfg;
  logic        adv;

  logic       chain_valid [0:BAR_CELLS];
  pixel_out_t chain_word  [0:BAR_CELLS];
  pixel_out_t out_word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left         <= '0;
      rect_top          <= '0;
      rect_right        <= '0;
      rect_bottom       <= '0;
      outline_thickness <= 8'd1;
      fill_color        <= '0;
      blend_alpha       <= ALPHA_MAX;
      draw_mode         <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RECT_LEFT:   rect_left         <= cfg_data[COORD_BITS-1:0];
        REG_RECT_TOP:    rect_top          <= cfg_data[COORD_BITS-1:0];
        REG_RECT_RIGHT:  rect_right        <= cfg_data[COORD_BITS-1:0];
        REG_RECT_BOTTOM: rect_bottom       <= cfg_data[COORD_BITS-1:0];
        REG_THICKNESS:   outline_thickness <= cfg_data[7:0];
        REG_FILL_COLOR:  fill_color        <= cfg_data[23:0];
        REG_BLEND_ALPHA: blend_alpha       <= cfg_data[7:0];
        REG_DRAW_MODE:   draw_mode         <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign bcfg.fill_color  = fill_color;
  assign bcfg.blend_alpha = blend_alpha;
  assign bcfg.draw_mode   = draw_mode;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  rop_cover #(
    .COORD_BITS(COORD_BITS)
  ) u_cover (
    .clk              (clk),
    .rst              (rst),
    .adv              (adv),
    .in_valid         (in_valid),
    .in_word          (in_word),
    .rect_left        (rect_left),
    .rect_top         (rect_top),
    .rect_right       (rect_right),
    .rect_bottom      (rect_bottom),
    .outline_thickness(outline_thickness),
    .draw_mode        (draw_mode),
    .cell_valid       (chain_valid[0]),
    .cell_word        (chain_word[0])
  );

  for (genvar i = 0; i < BAR_CELLS; i++) begin : g_cell
    rop_blend_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .cfg       (bcfg),
      .prev_valid(chain_valid[i]),
      .prev_word (chain_word[i]),
      .cell_valid(chain_valid[i+1]),
      .cell_word (chain_word[i+1])
    );
  end

  // on cover: set mode overwrites unless alpha is 0, blend mode forces opaque alpha
  always_comb begin
    out_word_next = chain_word[BAR_CELLS];
    if (chain_word[BAR_CELLS].cover_count != '0) begin
      if (!draw_mode[MODE_SET_BIT]) begin
        out_word_next.out_a = ALPHA_MAX;
      end else if (blend_alpha != '0) begin
        out_word_next.out_b = fill_color[7:0];
        out_word_next.out_g = fill_color[15:8];
        out_word_next.out_r = fill_color[23:16];
        out_word_next.out_a = blend_alpha;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain_valid[BAR_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= out_word_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.cover_count <= COUNT_W'(BAR_CELLS)))
    else $error("cover count above bar count");

  a_fill_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !draw_mode[MODE_OUTLINE_BIT]) |-> (out_word.cover_count <= 3'd1))
    else $error("fill mode reported more than one cover");

  a_blend_opaque: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !draw_mode[MODE_SET_BIT] && out_word.cover_count != '0)
      |-> (out_word.out_a == ALPHA_MAX))
    else $error("blended word not opaque");

  a_hold_chain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output held");

endmodule
`default_nettype wire
